// File: design/opfe_pkg.sv
// Shared types, constants and helper functions for the OLED page framebuffer engine.
// Used by opfe_front, opfe_queue, opfe_back and the top level; has no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package opfe_pkg;

    // Display geometry
    localparam int DISPLAY_COLUMNS = 128;
    localparam int PAGE_TOTAL      = 8;
    localparam int CHUNK_BYTES     = 16;

    // One store row holds one data chunk of one page
    localparam int CHUNKS_PER_PAGE = (DISPLAY_COLUMNS + CHUNK_BYTES - 1) / CHUNK_BYTES;
    localparam int ROW_COUNT       = PAGE_TOTAL * CHUNKS_PER_PAGE;
    localparam int ROW_BITS        = CHUNK_BYTES * 8;
    localparam int LAST_CHUNK_LEN  = DISPLAY_COLUMNS - (CHUNKS_PER_PAGE - 1) * CHUNK_BYTES;
    localparam int ROW_AW          = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int OFF_W           = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam int CHUNK_CW        = (CHUNKS_PER_PAGE > 1) ? $clog2(CHUNKS_PER_PAGE) : 1;
    // Reciprocal for x / CHUNK_BYTES with 16 fraction bits, exact for 8-bit x
    localparam int CHUNK_RECIP     = (65536 + CHUNK_BYTES - 1) / CHUNK_BYTES;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam logic [2:0] CFG_BUS_ADDRESS    = 3'd0;
    localparam logic [2:0] CFG_COLUMN_START   = 3'd1;
    localparam logic [2:0] CFG_CONTRAST_LEVEL = 3'd2;
    localparam logic [2:0] CFG_CLOCK_SETTING  = 3'd3;
    localparam logic [2:0] CFG_MUX_RATIO      = 3'd4;

    localparam logic [6:0] RST_BUS_ADDRESS    = 7'h3C;
    localparam logic [6:0] RST_COLUMN_START   = 7'd2;
    localparam logic [7:0] RST_CONTRAST_LEVEL = 8'd127;
    localparam logic [7:0] RST_CLOCK_SETTING  = 8'd128;
    localparam logic [5:0] RST_MUX_RATIO      = 6'd63;

    // Input op codes
    localparam logic [2:0] OP_INIT      = 3'd0;
    localparam logic [2:0] OP_ALL_ON    = 3'd1;
    localparam logic [2:0] OP_NORMAL    = 3'd2;
    localparam logic [2:0] OP_CLEAR     = 3'd3;
    localparam logic [2:0] OP_SET_PIXEL = 3'd4;
    localparam logic [2:0] OP_FLUSH     = 3'd5;

    // Control bytes and display commands
    localparam logic [7:0] CTRL_COMMAND  = 8'h00;
    localparam logic [7:0] CTRL_DATA     = 8'h40;
    localparam logic [7:0] CMD_PAGE      = 8'hB0;
    localparam logic [3:0] CMD_COL_LOW   = 4'h0;
    localparam logic [3:0] CMD_COL_HIGH  = 4'h1;
    localparam logic [7:0] CMD_ALL_ON    = 8'hA5;
    localparam logic [7:0] CMD_NORMAL    = 8'hA4;
    localparam logic [7:0] CMD_OFF       = 8'hAE;
    localparam logic [7:0] CMD_ON        = 8'hAF;
    localparam logic [7:0] CMD_CLK_DIV   = 8'hD5;
    localparam logic [7:0] CMD_MUX       = 8'hA8;
    localparam logic [7:0] CMD_OFFSET    = 8'hD3;
    localparam logic [7:0] CMD_ZERO      = 8'h00;
    localparam logic [7:0] CMD_START_LN  = 8'h40;
    localparam logic [7:0] CMD_SEG_REMAP = 8'hA1;
    localparam logic [7:0] CMD_COM_SCAN  = 8'hC8;
    localparam logic [7:0] CMD_CONTRAST  = 8'h81;
    localparam logic [7:0] CMD_NOT_INV   = 8'hA6;
    localparam logic [7:0] CMD_DCDC      = 8'hAD;
    localparam logic [7:0] CMD_DCDC_ON   = 8'h8B;
    localparam logic [4:0] INIT_LAST     = 5'd16;

    typedef enum logic [2:0] {
        K_INIT,
        K_ALL_ON,
        K_NORMAL,
        K_CLEAR,
        K_PIXEL,
        K_FLUSH
    } opfe_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_CMD,
        ST_PIX_WR,
        ST_FL_CMD,
        ST_FL_DATA
    } opfe_state_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic [2:0] page_index;
    } opfe_item_t;

    typedef struct packed {
        logic [6:0]  target_address;
        logic [7:0]  control_byte;
        logic [4:0]  payload_count;
        logic [63:0] payload_low;
        logic [63:0] payload_high;
        logic        last_of_run;
    } opfe_result_t;

    typedef struct packed {
        logic [6:0] bus_address;
        logic [6:0] column_start;
        logic [7:0] contrast_level;
        logic [7:0] clock_setting;
        logic [5:0] mux_ratio;
    } opfe_cfg_t;

    // Classified work item handed from front to back
    typedef struct packed {
        opfe_kind_t        kind;
        logic [ROW_AW-1:0] row;
        logic [OFF_W-1:0]  off;
        logic [2:0]        bit_sel;
        logic [2:0]        page;
    } opfe_entry_t;

    // Start-up command byte for one step of the init sequence
    function automatic logic [7:0] init_cmd(input logic [4:0] step, input opfe_cfg_t cfg);
        logic [7:0] cmd;
        case (step)
            5'd0:    cmd = CMD_OFF;
            5'd1:    cmd = CMD_CLK_DIV;
            5'd2:    cmd = cfg.clock_setting;
            5'd3:    cmd = CMD_MUX;
            5'd4:    cmd = {2'b00, cfg.mux_ratio};
            5'd5:    cmd = CMD_OFFSET;
            5'd6:    cmd = CMD_ZERO;
            5'd7:    cmd = CMD_START_LN;
            5'd8:    cmd = CMD_SEG_REMAP;
            5'd9:    cmd = CMD_COM_SCAN;
            5'd10:   cmd = CMD_CONTRAST;
            5'd11:   cmd = cfg.contrast_level;
            5'd12:   cmd = CMD_NOT_INV;
            5'd13:   cmd = CMD_DCDC;
            5'd14:   cmd = CMD_DCDC_ON;
            5'd15:   cmd = CMD_NORMAL;
            default: cmd = CMD_ON;
        endcase
        return cmd;
    endfunction

endpackage

`default_nettype wire

// File: design/opfe_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module opfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output      logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/opfe_front.sv
// Front end: decodes an input item into a queue entry and drops items with no effect.
// Depends on opfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module opfe_front (
    input  wire logic                 push,
    input  wire logic                 full,
    input  wire opfe_pkg::opfe_item_t item,
    output      logic                 enq,
    output      opfe_pkg::opfe_entry_t entry
);

    logic [24:0] prod;
    logic [7:0]  quot;
    logic [15:0] quot_x_chunk;
    logic [7:0]  rem;
    logic [15:0] row_full;
    logic        visible;
    logic        page_ok;
    logic        keep;

    // Column to chunk split by reciprocal multiply
    assign prod         = 25'(item.pixel_x) * 25'(opfe_pkg::CHUNK_RECIP);
    assign quot         = prod[23:16];
    assign quot_x_chunk = 16'(quot) * 16'(opfe_pkg::CHUNK_BYTES);
    assign rem          = item.pixel_x - quot_x_chunk[7:0];
    assign row_full     = 16'(item.pixel_y[7:3]) * 16'(opfe_pkg::CHUNKS_PER_PAGE) + 16'(quot);

    assign visible = ({1'b0, item.pixel_x} < 9'(opfe_pkg::DISPLAY_COLUMNS))
                  && ({1'b0, item.pixel_y} < 9'(8 * opfe_pkg::PAGE_TOTAL));
    assign page_ok = ({2'b00, item.page_index} < 5'(opfe_pkg::PAGE_TOTAL));

    always_comb
    begin
        entry.row     = row_full[opfe_pkg::ROW_AW-1:0];
        entry.off     = rem[opfe_pkg::OFF_W-1:0];
        entry.bit_sel = item.pixel_y[2:0];
        entry.page    = item.page_index;
        entry.kind    = opfe_pkg::K_INIT;
        keep          = 1'b1;
        case (item.op)
            opfe_pkg::OP_INIT:      entry.kind = opfe_pkg::K_INIT;
            opfe_pkg::OP_ALL_ON:    entry.kind = opfe_pkg::K_ALL_ON;
            opfe_pkg::OP_NORMAL:    entry.kind = opfe_pkg::K_NORMAL;
            opfe_pkg::OP_CLEAR:     entry.kind = opfe_pkg::K_CLEAR;
            opfe_pkg::OP_SET_PIXEL:
            begin
                entry.kind = opfe_pkg::K_PIXEL;
                keep       = visible;
            end
            opfe_pkg::OP_FLUSH:
            begin
                entry.kind = opfe_pkg::K_FLUSH;
                keep       = page_ok;
            end
            default:                keep = 1'b0;
        endcase
    end

    assign enq = push && !full && keep;

endmodule

`default_nettype wire

// File: design/opfe_queue.sv
// Short FIFO of decoded entries between the front end and the back end.
// Depends on opfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module opfe_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  enq,
    input  wire opfe_pkg::opfe_entry_t entry,
    input  wire logic                  deq,
    output      logic                  full,
    output      logic                  valid,
    output      opfe_pkg::opfe_entry_t head
);

    opfe_pkg::opfe_entry_t           slot_reg [opfe_pkg::QUEUE_DEPTH];
    logic [opfe_pkg::QUEUE_PW-1:0]   wptr_reg, wptr_next;
    logic [opfe_pkg::QUEUE_PW-1:0]   rptr_reg, rptr_next;
    logic [opfe_pkg::QUEUE_CW-1:0]   count_reg, count_next;
    logic                            do_deq;

    assign full   = (count_reg == opfe_pkg::QUEUE_CW'(opfe_pkg::QUEUE_DEPTH));
    assign valid  = (count_reg != '0);
    assign head   = slot_reg[rptr_reg];
    assign do_deq = deq && valid;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (enq)
        begin
            wptr_next = (wptr_reg == opfe_pkg::QUEUE_PW'(opfe_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wptr_reg + 1'b1;
        end
        if (do_deq)
        begin
            rptr_next = (rptr_reg == opfe_pkg::QUEUE_PW'(opfe_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rptr_reg + 1'b1;
        end
        if (enq && !do_deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_deq && !enq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            slot_reg[wptr_reg] <= entry;
        end
    end

endmodule

`default_nettype wire

// File: design/opfe_back.sv
// Back end: runs one queue entry at a time, owns the frame store and the result register.
// Depends on opfe_pkg and opfe_ram.
`timescale 1ns / 1ps
`default_nettype none

module opfe_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_valid,
    input  wire opfe_pkg::opfe_entry_t  q_head,
    output      logic                   q_pop,
    input  wire opfe_pkg::opfe_cfg_t    cfg,
    input  wire logic                   pop,
    output      logic                   res_valid,
    output      opfe_pkg::opfe_result_t result
);

    localparam int RW = opfe_pkg::ROW_AW;
    localparam int RB = opfe_pkg::ROW_BITS;
    localparam int CW = opfe_pkg::CHUNK_CW;

    opfe_pkg::opfe_state_t  state_reg, state_next;
    logic [4:0]             step_reg, step_next;
    logic [CW-1:0]          chunk_reg, chunk_next;
    opfe_pkg::opfe_entry_t  cur_reg, cur_next;
    opfe_pkg::opfe_result_t res_reg;
    logic                   res_valid_reg;
    logic [opfe_pkg::ROW_COUNT-1:0] valid_reg;

    logic          slot_free;
    logic          emit;
    logic [7:0]    e_ctrl;
    logic [4:0]    e_count;
    logic [127:0]  e_payload;
    logic          e_last;
    logic          clear_all;
    logic          set_valid;
    logic          ram_we;
    logic          ram_re;
    logic [RW-1:0] ram_raddr;
    logic [RB-1:0] ram_wdata;
    logic [RB-1:0] ram_rdata;
    logic [RB-1:0] old_row;
    logic [RB-1:0] data_row;
    logic [15:0]   flush_row_full;
    logic [RW-1:0] flush_row;
    logic          last_chunk;
    logic [7:0]    cmd;

    assign slot_free      = !res_valid_reg || pop;
    assign flush_row_full = 16'(cur_reg.page) * 16'(opfe_pkg::CHUNKS_PER_PAGE) + 16'(chunk_reg);
    assign flush_row      = flush_row_full[RW-1:0];
    assign last_chunk     = (chunk_reg == CW'(opfe_pkg::CHUNKS_PER_PAGE - 1));
    // Rows never written since the last clear read as zero
    assign old_row        = valid_reg[cur_reg.row] ? ram_rdata : '0;
    assign data_row       = valid_reg[flush_row] ? ram_rdata : '0;
    // Bit position in the row is byte offset * 8 + row bit
    assign ram_wdata      = old_row | (RB'(1) << {cur_reg.off, cur_reg.bit_sel});

    opfe_ram #(
        .WIDTH(RB),
        .DEPTH(opfe_pkg::ROW_COUNT)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(cur_reg.row),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            opfe_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_head.kind)
                        opfe_pkg::K_INIT:   state_next = opfe_pkg::ST_INIT;
                        opfe_pkg::K_ALL_ON: state_next = opfe_pkg::ST_CMD;
                        opfe_pkg::K_NORMAL: state_next = opfe_pkg::ST_CMD;
                        opfe_pkg::K_PIXEL:  state_next = opfe_pkg::ST_PIX_WR;
                        opfe_pkg::K_FLUSH:  state_next = opfe_pkg::ST_FL_CMD;
                        default:            state_next = opfe_pkg::ST_IDLE;
                    endcase
                end
            end
            opfe_pkg::ST_INIT:
            begin
                if (slot_free && step_reg == opfe_pkg::INIT_LAST)
                begin
                    state_next = opfe_pkg::ST_IDLE;
                end
            end
            opfe_pkg::ST_CMD:
            begin
                if (slot_free)
                begin
                    state_next = opfe_pkg::ST_IDLE;
                end
            end
            opfe_pkg::ST_PIX_WR:
            begin
                state_next = opfe_pkg::ST_IDLE;
            end
            opfe_pkg::ST_FL_CMD:
            begin
                if (slot_free && step_reg == 5'd2)
                begin
                    state_next = opfe_pkg::ST_FL_DATA;
                end
            end
            opfe_pkg::ST_FL_DATA:
            begin
                if (slot_free && last_chunk)
                begin
                    state_next = opfe_pkg::ST_IDLE;
                end
            end
            default: state_next = opfe_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath controls
    always_comb
    begin
        q_pop      = 1'b0;
        emit       = 1'b0;
        e_ctrl     = opfe_pkg::CTRL_COMMAND;
        e_count    = 5'd1;
        e_payload  = '0;
        e_last     = 1'b0;
        clear_all  = 1'b0;
        set_valid  = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = flush_row;
        step_next  = step_reg;
        chunk_next = chunk_reg;
        cur_next   = cur_reg;
        cmd        = opfe_pkg::CMD_NORMAL;
        case (state_reg)
            opfe_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_head;
                    step_next  = '0;
                    chunk_next = '0;
                    clear_all  = (q_head.kind == opfe_pkg::K_CLEAR);
                    // Pixel update: fetch the row now, merge and write next cycle
                    ram_re     = (q_head.kind == opfe_pkg::K_PIXEL);
                    ram_raddr  = q_head.row;
                end
            end
            opfe_pkg::ST_INIT:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    e_payload = 128'(opfe_pkg::init_cmd(step_reg, cfg));
                    e_last    = (step_reg == opfe_pkg::INIT_LAST);
                    step_next = step_reg + 1'b1;
                end
            end
            opfe_pkg::ST_CMD:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    cmd       = (cur_reg.kind == opfe_pkg::K_ALL_ON)
                                ? opfe_pkg::CMD_ALL_ON : opfe_pkg::CMD_NORMAL;
                    e_payload = 128'(cmd);
                    e_last    = 1'b1;
                end
            end
            opfe_pkg::ST_PIX_WR:
            begin
                ram_we    = 1'b1;
                set_valid = 1'b1;
            end
            opfe_pkg::ST_FL_CMD:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    case (step_reg)
                        5'd0:    cmd = opfe_pkg::CMD_PAGE | {5'b00000, cur_reg.page};
                        5'd1:    cmd = {opfe_pkg::CMD_COL_LOW, cfg.column_start[3:0]};
                        default: cmd = {opfe_pkg::CMD_COL_HIGH, 1'b0, cfg.column_start[6:4]};
                    endcase
                    e_payload = 128'(cmd);
                    step_next = step_reg + 1'b1;
                    // First chunk read overlaps the last addressing command
                    ram_re    = (step_reg == 5'd2);
                end
            end
            opfe_pkg::ST_FL_DATA:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    e_ctrl    = opfe_pkg::CTRL_DATA;
                    e_count   = last_chunk ? 5'(opfe_pkg::LAST_CHUNK_LEN)
                                           : 5'(opfe_pkg::CHUNK_BYTES);
                    e_payload = 128'(data_row);
                    e_last    = last_chunk;
                    if (!last_chunk)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = flush_row + 1'b1;
                        chunk_next = chunk_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= opfe_pkg::ST_IDLE;
            step_reg      <= '0;
            chunk_reg     <= '0;
            res_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            chunk_reg <= chunk_next;
            if (emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
            if (clear_all)
            begin
                valid_reg <= '0;
            end
            else if (set_valid)
            begin
                valid_reg[cur_reg.row] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            res_reg.target_address <= cfg.bus_address;
            res_reg.control_byte   <= e_ctrl;
            res_reg.payload_count  <= e_count;
            res_reg.payload_low    <= e_payload[63:0];
            res_reg.payload_high   <= e_payload[127:64];
            res_reg.last_of_run    <= e_last;
        end
    end

    assign res_valid = res_valid_reg;
    assign result    = res_reg;

endmodule

`default_nettype wire

// File: design/oled_page_framebuffer_engine_core.sv
// Top level of the OLED page framebuffer engine: configuration registers and queue ports.
// Depends on opfe_pkg, opfe_front, opfe_queue and opfe_back.
`timescale 1ns / 1ps
`default_nettype none

// Host-side engine for a page-organized monochrome OLED controller (128 columns by
// 8 pages of 8 rows by default). Items enter through a push/full queue port and each
// bus transaction leaves as one result on an empty/pop queue port; last_of_run marks
// the final transaction of an item. The front decodes an item in the cycle it is
// pushed and drops those with no effect (unused op codes, pixels off the display,
// pages out of range); a two-entry queue sits between it and the back end, so items
// keep being taken while the back end works or a result waits to be popped. The back
// end handles one entry at a time and first takes it off the queue in a dispatch
// step: clear is done in that step, set pixel adds a write step (row read on dispatch,
// merged write next cycle on the one frame store port), init adds 17 transfers,
// all-on and normal 1 transfer each, and flush page 3 command transfers plus one data
// transfer per 16-byte chunk. With pop held high one transfer leaves per cycle; a slow
// pop stretches the items that make transfers. Results leave from a single output
// register. The frame store is a RAM of one row per page chunk with a valid bit per
// row; reset and clear drop all valid bits at once, so there is no clearing pass and
// the block takes items right after reset. Configuration is on an APB-style port
// (registers at 4*i, always ready) and should be written only while the block is
// idle.
module oled_page_framebuffer_engine_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Item port
    input  wire logic                           push,
    output      logic                           full,
    input  wire opfe_pkg::opfe_item_t           item,
    // Result port
    output      logic                           empty,
    input  wire logic                           pop,
    output      opfe_pkg::opfe_result_t         result,
    // Configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [opfe_pkg::APB_AW-1:0]    paddr,
    input  wire logic [opfe_pkg::APB_DW-1:0]    pwdata,
    output      logic [opfe_pkg::APB_DW-1:0]    prdata,
    output      logic                           pready
);

    opfe_pkg::opfe_cfg_t   cfg_reg;
    opfe_pkg::opfe_entry_t entry;
    opfe_pkg::opfe_entry_t q_head;
    logic                  enq;
    logic                  q_valid;
    logic                  q_pop;
    logic                  res_valid;
    logic                  cfg_wr;
    logic [2:0]            cfg_idx;

    // ------------------------------------------------------------------
    // Configuration registers: a write transfer lands on the access cycle
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bus_address    <= opfe_pkg::RST_BUS_ADDRESS;
            cfg_reg.column_start   <= opfe_pkg::RST_COLUMN_START;
            cfg_reg.contrast_level <= opfe_pkg::RST_CONTRAST_LEVEL;
            cfg_reg.clock_setting  <= opfe_pkg::RST_CLOCK_SETTING;
            cfg_reg.mux_ratio      <= opfe_pkg::RST_MUX_RATIO;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                opfe_pkg::CFG_BUS_ADDRESS:    cfg_reg.bus_address    <= pwdata[6:0];
                opfe_pkg::CFG_COLUMN_START:   cfg_reg.column_start   <= pwdata[6:0];
                opfe_pkg::CFG_CONTRAST_LEVEL: cfg_reg.contrast_level <= pwdata[7:0];
                opfe_pkg::CFG_CLOCK_SETTING:  cfg_reg.clock_setting  <= pwdata[7:0];
                opfe_pkg::CFG_MUX_RATIO:      cfg_reg.mux_ratio      <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    // Read-back; addresses past the last register read as zero
    always_comb
    begin
        case (cfg_idx)
            opfe_pkg::CFG_BUS_ADDRESS:    prdata = 32'(cfg_reg.bus_address);
            opfe_pkg::CFG_COLUMN_START:   prdata = 32'(cfg_reg.column_start);
            opfe_pkg::CFG_CONTRAST_LEVEL: prdata = 32'(cfg_reg.contrast_level);
            opfe_pkg::CFG_CLOCK_SETTING:  prdata = 32'(cfg_reg.clock_setting);
            opfe_pkg::CFG_MUX_RATIO:      prdata = 32'(cfg_reg.mux_ratio);
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Front: decode the pushed item into a queue entry
    // ------------------------------------------------------------------
    opfe_front u_front (
        .push (push),
        .full (full),
        .item (item),
        .enq  (enq),
        .entry(entry)
    );

    // ------------------------------------------------------------------
    // Decoupling queue; full backs up straight to the item port
    // ------------------------------------------------------------------
    opfe_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .enq  (enq),
        .entry(entry),
        .deq  (q_pop),
        .full (full),
        .valid(q_valid),
        .head (q_head)
    );

    // ------------------------------------------------------------------
    // Back: sequencer, frame store and result register
    // ------------------------------------------------------------------
    opfe_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .cfg      (cfg_reg),
        .pop      (pop),
        .res_valid(res_valid),
        .result   (result)
    );

    assign empty = !res_valid;

endmodule

`default_nettype wire
